FILE: sv/tri_pkg.sv
// Shared types for the two-resource interval feasibility block.
`default_nettype none
package tri_pkg;
  localparam int TIME_WIDTH = 32;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] start_time;
    logic [TIME_WIDTH-1:0] end_time;
    logic                  is_last;
  } in_beat_t;

  typedef struct packed {
    logic feasible;
    logic overflow;
  } out_beat_t;
endpackage
`default_nettype wire

FILE: sv/two_resource_interval_feasibility.sv
// Top level: interval store, insertion sort over a memory, greedy two-resource scan.
//
// Usage: send intervals as beats on in_ (valid/stall); the beat with is_last set
// closes the set. One result beat then appears on out_: feasible is 1 when every
// stored interval was placed on one of two resources, overflow is 1 when beats
// were dropped because the store of MAX_INTERVALS entries was full.
// While loading, every beat with in_valid high is taken. After the last beat the
// store is sorted by end time then start time with an insertion sort through a
// single-port-write, single-read memory: each shift reads entry j-1 (ST_SCMP),
// then writes it to slot j (ST_SIN). The greedy scan then reads each entry
// (ST_GREAD) and places it (ST_GSTEP). in_stall is high from the last beat until
// the result is registered, and longer while an earlier result still waits.
// The result is held while out_stall is high.
// Reset clears the count, overflow flag and sequencer; the store needs no reset.
`default_nettype none
module two_resource_interval_feasibility #(
  parameter int MAX_INTERVALS = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tri_pkg::in_beat_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tri_pkg::out_beat_t       out_data
);
  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int TW = tri_pkg::TIME_WIDTH;

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_SOUT  = 7'b0000010,
    ST_SCMP  = 7'b0000100,
    ST_SIN   = 7'b0001000,
    ST_GREAD = 7'b0010000,
    ST_GSTEP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  logic [2*TW-1:0] mem [MAX_INTERVALS];
  logic [2*TW-1:0] rd_r;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [2*TW-1:0] held_r, held_nxt;
  logic [TW:0]     f1_r, f1_nxt, f2_r, f2_nxt;
  logic            ok_r, ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  tri_pkg::out_beat_t out_r, out_nxt;

  logic            we;
  logic [AW-1:0]   wa, ra;
  logic [2*TW-1:0] wd;
  logic            accept;
  logic [TW-1:0]   hs, he, rs, re;
  logic            held_before;
  logic [TW:0]     st;
  logic            fit1, fit2;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // {start, end} packing; compare on end then start
  assign hs = held_r[2*TW-1:TW];
  assign he = held_r[TW-1:0];
  assign rs = rd_r[2*TW-1:TW];
  assign re = rd_r[TW-1:0];
  assign held_before = (he != re) ? (he < re) : (hs < rs);
  assign st = {1'b0, rs};
  // free mark is all ones with top bit set: treat top bit as negative
  assign fit1 = f1_r[TW] ? 1'b1 : (st > f1_r);
  assign fit2 = f2_r[TW] ? 1'b1 : (st > f2_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    i_nxt = i_r;
    j_nxt = j_r;
    held_nxt = held_r;
    f1_nxt = f1_r;
    f2_nxt = f2_r;
    ok_nxt = ok_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    we = 1'b0;
    wa = cnt_r[AW-1:0];
    wd = {in_data.start_time[TW-1:0], in_data.end_time[TW-1:0]};
    ra = i_r[AW-1:0];
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_r < CW'(MAX_INTERVALS)) begin
            we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.is_last) begin
            i_nxt = CW'(1);
            state_nxt = ST_SOUT;
          end
        end
      end
      // fetch entry i into held, or start the greedy scan once every entry is sorted
      ST_SOUT: begin
        if (i_r >= cnt_r) begin
          i_nxt = '0;
          f1_nxt = '1;
          f2_nxt = '1;
          ok_nxt = 1'b1;
          state_nxt = ST_GREAD;
        end else begin
          ra = i_r[AW-1:0];
          j_nxt = i_r;
          state_nxt = ST_SCMP;
        end
      end
      // on the first pass (j == i) load held from rd_r; read j-1
      ST_SCMP: begin
        if (j_r == i_r) begin
          held_nxt = rd_r;
        end
        ra = AW'(j_r - 1'b1);
        state_nxt = ST_SIN;
      end
      // shift j-1 up or drop held at j
      ST_SIN: begin
        we = 1'b1;
        wa = j_r[AW-1:0];
        if (held_before) begin
          wd = rd_r;
          j_nxt = j_r - 1'b1;
          // bottom reached: drop held into slot 0 next
          if (j_r == CW'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCMP;
          end
        end else begin
          wd = held_r;
          i_nxt = i_r + 1'b1;
          state_nxt = ST_SOUT;
        end
      end
      ST_DONE: begin
        we = 1'b1;
        wa = '0;
        wd = held_r;
        i_nxt = i_r + 1'b1;
        state_nxt = ST_SOUT;
      end
      ST_GREAD: begin
        if (i_r >= cnt_r) begin
          // hold the verdict until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_nxt = 1'b1;
            out_nxt.feasible = ok_r;
            out_nxt.overflow = ovf_r;
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            state_nxt = ST_LOAD;
          end
        end else begin
          ra = i_r[AW-1:0];
          i_nxt = i_r + 1'b1;
          state_nxt = ST_GSTEP;
        end
      end
      ST_GSTEP: begin
        priority if (fit1 && fit2) begin
          if ($signed(f1_r) >= $signed(f2_r)) begin
            f1_nxt = {1'b0, re};
          end else begin
            f2_nxt = {1'b0, re};
          end
        end else if (fit1) begin
          f1_nxt = {1'b0, re};
        end else if (fit2) begin
          f2_nxt = {1'b0, re};
        end else begin
          ok_nxt = 1'b0;
        end
        state_nxt = ST_GREAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      ok_r        <= 1'b1;
      f1_r        <= '1;
      f2_r        <= '1;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      ok_r        <= ok_nxt;
      f1_r        <= f1_nxt;
      f2_r        <= f2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end
endmodule
`default_nettype wire
